/* hw/rtl/cartesian_to_cylindrical_corners_core_defines.svh */
// assertion macros for the cylindrical corner converter
`ifndef CARTESIAN_TO_CYLINDRICAL_CORNERS_CORE_DEFINES_SVH
`define CARTESIAN_TO_CYLINDRICAL_CORNERS_CORE_DEFINES_SVH
`define C2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C2C_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

/* hw/rtl/c2c_pkg.sv */
// package for the cylindrical corner converter
`default_nettype none
package c2c_pkg;
  localparam int MaxPointsDef = 8;
  localparam int CordicStepsDef = 18;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [20:0] TwoPiQ16 = 21'sd411774;
  localparam logic signed [23:0] HalfPiQ20 = 24'sd1647099;
  localparam logic [23:0] KinvQ24 = 24'd10188014;
  localparam logic signed [19:0] AngMax = 20'sh7FFFF;
  localparam logic signed [19:0] AngMin = -20'sh80000;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0, CFG_ORIGIN_Y = 3'd1, CFG_ORIGIN_Z = 3'd2,
    CFG_ROT_COL0 = 3'd3, CFG_ROT_COL1 = 3'd4, CFG_ROT_COL2 = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ROUND, ST_PRE, ST_CORDIC, ST_SCALE, ST_FINISH,
    ST_CHECK, ST_WRAP, ST_WRAP_CHK, ST_EMIT, ST_SEND
  } state_t;

  function automatic logic signed [23:0] atan_q20(input logic [5:0] i);
    logic signed [23:0] r;
    case (i)
      6'd0: r = 24'sd823550;
      6'd1: r = 24'sd486170;
      6'd2: r = 24'sd256879;
      6'd3: r = 24'sd130396;
      6'd4: r = 24'sd65451;
      6'd5: r = 24'sd32757;
      6'd6: r = 24'sd16383;
      default: r = (i <= 6'd20) ? (24'sd1 <<< (6'd20 - i)) : 24'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/c2c_ram.sv */
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module c2c_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/cartesian_to_cylindrical_corners_core.sv */
// cylindrical corner converter, top level
// channel | dir | contents
// in_     | in  | tdata {z,y,x}, tlast last_point
// out_    | out | tdata {height,angle,radius,point_index}, tuser range_error, tlast
// cfg_    | in  | register index and 48 bit data
// a point takes multiply-accumulate steps on one shared 34x16 multiplier with the
// rounding folded in, a load and a quadrant turn, CordicSteps shift-add steps,
// a scale multiply and a store; a new request is taken only once the point is stored
// the last point adds a spread check, a wrap pass over the stored points when needed
// and an emit and a send step per result; out_tready low holds the result in place
// reset is synchronous; in_tready is low while a point or emit is in work
`default_nettype none
`include "cartesian_to_cylindrical_corners_core_defines.svh"
module cartesian_to_cylindrical_corners_core
  import c2c_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDef,
  parameter int CordicSteps = CordicStepsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // coord_x, coord_y, coord_z
  input  wire logic        in_tlast,   // last_point
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // point_index, radius, angle, height, zero pad
  output logic             out_tuser,  // range_error
  output logic             out_tlast,  // last_result
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  localparam int AW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int SW = $clog2(CordicSteps + 1);

  state_t st_r, st_nxt;
  logic signed [31:0] org_r [3];
  logic [47:0] col_r [3];
  logic signed [32:0] d_r [3];
  logic signed [52:0] acc_r;
  logic signed [36:0] loc_r [3];
  logic last_r;
  logic [1:0] i_r, j_r;
  logic [SW-1:0] it_r;
  logic signed [38:0] x_r, y_r;
  logic signed [23:0] z_r;
  logic axis_r;
  logic [CW-1:0] cnt_r;
  logic signed [19:0] mn_r, mx_r;
  logic err_r;
  logic [AW-1:0] ptr_r;
  logic [31:0] rad_r;
  logic signed [19:0] ang_r;
  logic signed [31:0] hgt_r;
  logic [83:0] wdata, rdata;
  logic we;
  logic [AW-1:0] waddr;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == ST_IDLE);

  // shared multiplier
  logic signed [15:0] m_a;
  logic signed [33:0] m_b;
  logic signed [49:0] m_p;
  always_comb begin
    m_a = col_r[i_r][16*j_r +: 16];
    m_b = {d_r[j_r][32], d_r[j_r]};
    if (st_r == ST_SCALE) begin
      m_a = 16'sd0;
      m_b = 34'sd0;
    end
    m_p = m_a * m_b;
  end
  logic [63:0] sc_p;
  assign sc_p = x_r[38:0] * KinvQ24;

  logic signed [38:0] dx, dy;
  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;

  logic signed [23:0] zr;
  logic signed [19:0] ang_c;
  logic [39:0] rsum;
  always_comb begin
    zr = (z_r + 24'sd8) >>> 4;
    if (zr > 24'(PiQ16)) ang_c = PiQ16;
    else if (zr < -24'(PiQ16) + 24'sd1) ang_c = -PiQ16 + 20'sd1;
    else ang_c = zr[19:0];
    rsum = sc_p[63:24] + 40'(sc_p[23]);
  end

  logic signed [19:0] wr_ang;
  assign wr_ang = rdata[51:32];
  logic signed [19:0] wrapped;
  assign wrapped = wr_ang[19] ? 20'(21'(wr_ang) + TwoPiQ16) : wr_ang;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = (cnt_r == CW'(MaxPoints)) ?
                 (in_tlast ? ST_CHECK : ST_IDLE) : ST_MUL;
      ST_MUL: if (i_r == 2'd2 && j_r == 2'd2) st_nxt = ST_ROUND;
      ST_ROUND: st_nxt = ST_PRE;
      ST_PRE: st_nxt = ST_CORDIC;
      ST_CORDIC: if (it_r == SW'(CordicSteps - 1)) st_nxt = ST_SCALE;
      ST_SCALE: st_nxt = ST_FINISH;
      ST_FINISH: st_nxt = last_r ? ST_CHECK : ST_IDLE;
      ST_CHECK: st_nxt = (cnt_r == '0) ? ST_IDLE :
                 (21'(mx_r) - 21'(mn_r) > 21'(PiQ16)) ? ST_WRAP : ST_EMIT;
      ST_WRAP: st_nxt = ST_WRAP_CHK;
      ST_WRAP_CHK: if (CW'(ptr_r) + 1'b1 == cnt_r) st_nxt = ST_EMIT;
                   else st_nxt = ST_WRAP;
      ST_EMIT: st_nxt = ST_SEND;
      ST_SEND: if (out_tready) st_nxt = (CW'(ptr_r) + 1'b1 == cnt_r) ? ST_IDLE : ST_EMIT;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = {hgt_r, ang_c, rad_r};
    if (st_r == ST_FINISH) we = 1'b1;
    if (st_r == ST_WRAP_CHK) begin
      we = 1'b1;
      waddr = ptr_r;
      wdata = {rdata[83:52], wrapped, rdata[31:0]};
    end
  end

  c2c_ram #(.Width(84), .Depth(MaxPoints)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ptr_r), .rdata(rdata)
  );

  assign out_tvalid = (st_r == ST_SEND);
  assign out_tdata = {1'b0, rdata[83:52], rdata[51:32], rdata[31:0], 3'(ptr_r)};
  assign out_tuser = err_r;
  assign out_tlast = (CW'(ptr_r) + 1'b1 == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      mn_r <= AngMax;
      mx_r <= AngMin;
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      col_r[0] <= 48'd16384;
      col_r[1] <= 48'd1073741824;
      col_r[2] <= 48'd70368744177664;
      err_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ORIGIN_X: org_r[0] <= cfg_data[31:0];
          CFG_ORIGIN_Y: org_r[1] <= cfg_data[31:0];
          CFG_ORIGIN_Z: org_r[2] <= cfg_data[31:0];
          CFG_ROT_COL0: col_r[0] <= cfg_data;
          CFG_ROT_COL1: col_r[1] <= cfg_data;
          CFG_ROT_COL2: col_r[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: begin
          ptr_r <= '0;
          err_r <= 1'b0;
          if (in_tvalid) begin
            for (int k = 0; k < 3; k++)
              d_r[k] <= 33'(signed'(in_tdata[32*k +: 32])) - 33'(org_r[k]);
            last_r <= in_tlast;
            i_r <= '0; j_r <= '0; acc_r <= '0;
          end
        end
        ST_MUL: begin
          if (j_r == 2'd2) begin
            loc_r[i_r] <= 37'((acc_r + 53'(m_p) + 53'sd8192) >>> 14);
            acc_r <= '0;
            j_r <= '0;
            i_r <= i_r + 2'd1;
          end else begin
            acc_r <= acc_r + 53'(m_p);
            j_r <= j_r + 2'd1;
          end
        end
        ST_ROUND: begin
          x_r <= 39'(loc_r[0]);
          y_r <= 39'(loc_r[1]);
          z_r <= '0;
          it_r <= '0;
          axis_r <= (loc_r[0] == '0) && (loc_r[1] == '0);
          if (loc_r[2] > 37'sd2147483647) hgt_r <= 32'sh7FFFFFFF;
          else if (loc_r[2] < -37'sd2147483648) hgt_r <= 32'sh80000000;
          else hgt_r <= loc_r[2][31:0];
        end
        ST_PRE: begin
          if (x_r < 0) begin
            if (y_r >= 0) begin
              x_r <= y_r; y_r <= -x_r; z_r <= HalfPiQ20;
            end else begin
              x_r <= -y_r; y_r <= x_r; z_r <= -HalfPiQ20;
            end
          end
        end
        ST_CORDIC: begin
          if (y_r >= 0) begin
            x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + atan_q20(6'(it_r));
          end else begin
            x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - atan_q20(6'(it_r));
          end
          it_r <= it_r + 1'b1;
        end
        ST_SCALE: begin
          if (axis_r) begin
            rad_r <= '0;
            z_r <= -24'sd8;
          end else begin
            rad_r <= (rsum > 40'hFFFFFFFF) ? 32'hFFFFFFFF : rsum[31:0];
          end
        end
        ST_FINISH: begin
          cnt_r <= cnt_r + 1'b1;
          if (ang_c > mx_r) mx_r <= ang_c;
          if (ang_c < mn_r) mn_r <= ang_c;
        end
        ST_CHECK: begin
          ptr_r <= '0;
          if (cnt_r == '0) begin
            mn_r <= AngMax; mx_r <= AngMin;
          end else if (21'(mx_r) - 21'(mn_r) > 21'(PiQ16)) begin
            mn_r <= AngMax; mx_r <= AngMin;
          end
        end
        ST_WRAP: ;
        ST_WRAP_CHK: begin
          if (wrapped > mx_r) mx_r <= wrapped;
          if (wrapped < mn_r) mn_r <= wrapped;
          if (CW'(ptr_r) + 1'b1 == cnt_r) begin
            ptr_r <= '0;
            err_r <= (21'(wrapped > mx_r ? wrapped : mx_r) -
                      21'(wrapped < mn_r ? wrapped : mn_r)) > 21'(PiQ16);
          end else ptr_r <= ptr_r + 1'b1;
        end
        ST_EMIT: ;
        ST_SEND: if (out_tready) begin
          if (CW'(ptr_r) + 1'b1 == cnt_r) begin
            cnt_r <= '0; mn_r <= AngMax; mx_r <= AngMin; ptr_r <= '0;
          end else ptr_r <= ptr_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `C2C_NEVER(a_cnt_range, cnt_r > CW'(MaxPoints), "point count overflow")
  `C2C_NEVER(a_busy_out, out_tvalid && in_tready, "result while taking points")
  `C2C_ASSERT(a_last_clear, (out_tvalid && out_tready && out_tlast) |=> (cnt_r == '0),
              "count not cleared after run")
  `C2C_NEVER(a_emit_empty, out_tvalid && (cnt_r == '0), "result with empty store")
endmodule
`default_nettype wire

/* test/tb_cartesian_to_cylindrical_corners_core.sv */
// testbench for the cylindrical corner converter: predicts each element's output run and compares
module tb_cartesian_to_cylindrical_corners_core
  import c2c_pkg::*;
();

  typedef struct packed {
    logic [2:0]  point_index;
    logic [31:0] radius;
    logic [19:0] angle;
    logic [31:0] height;
    logic        range_error;
    logic        last_result;
  } corner_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  cartesian_to_cylindrical_corners_core DUT (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [31:0] org_x, org_y, org_z;
  logic [47:0] rot_col [3];
  logic [31:0] rad_mem [8];
  logic signed [31:0] ang_mem [8];
  logic signed [31:0] hgt_mem [8];
  int stored_count;
  int ang_lo, ang_hi;

  corner_t expected_corners [$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(input int i);
    longint heads [7] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383};
    if (i < 7) return heads[i];
    if (i <= 20) return longint'(1) << (20 - i);
    return 0;
  endfunction

  task automatic polar_of(input longint xi, input longint yi,
                          output logic [31:0] rad, output int ang);
    longint x, y, z, t, dx, dy, a;
    logic [63:0] r;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) begin
      rad = '0; ang = 0;
      return;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 1647099;
      end else begin
        t = x; x = -y; y = t; z = -1647099;
      end
    end
    for (int i = 0; i < 18; i++) begin
      dx = floor_shift(y, i); dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    r = (64'(x) * 64'd10188014 + (64'd1 << 23)) >> 24;
    rad = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    a = floor_shift(z + 8, 4);
    if (a > 205887) a = 205887;
    if (a < -205886) a = -205886;
    ang = int'(a);
  endtask

  task automatic predict_point(input logic [95:0] data, input logic last);
    longint d [3], loc [3], s, h;
    logic [31:0] rad;
    int ang, n;
    bit err;
    corner_t c;
    if (stored_count < 8) begin
      d[0] = longint'($signed(data[31:0])) - org_x;
      d[1] = longint'($signed(data[63:32])) - org_y;
      d[2] = longint'($signed(data[95:64])) - org_z;
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++)
          s += longint'($signed(rot_col[i][16*j +: 16])) * d[j];
        loc[i] = floor_shift(s + 8192, 14);
      end
      polar_of(loc[0], loc[1], rad, ang);
      h = loc[2];
      if (h > 64'sd2147483647) h = 2147483647;
      if (h < -64'sd2147483648) h = -2147483648;
      rad_mem[stored_count] = rad;
      ang_mem[stored_count] = ang;
      hgt_mem[stored_count] = int'(h);
      if (ang > ang_hi) ang_hi = ang;
      if (ang < ang_lo) ang_lo = ang;
      stored_count++;
    end
    if (!last) return;
    n = stored_count; err = 0;
    if (n > 0 && ang_hi - ang_lo > 205887) begin
      ang_lo = 524287; ang_hi = -524288;
      for (int i = 0; i < n; i++) begin
        if (ang_mem[i] < 0) ang_mem[i] += 411774;
        if (ang_mem[i] > ang_hi) ang_hi = ang_mem[i];
        if (ang_mem[i] < ang_lo) ang_lo = ang_mem[i];
      end
      if (ang_hi - ang_lo > 205887) err = 1;
    end
    for (int i = 0; i < n; i++) begin
      c.point_index = i[2:0];
      c.radius = rad_mem[i];
      c.angle = ang_mem[i][19:0];
      c.height = hgt_mem[i];
      c.range_error = err;
      c.last_result = (i == n - 1);
      expected_corners.push_back(c);
    end
    stored_count = 0; ang_lo = 524287; ang_hi = -524288;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_X: org_x = value[31:0];
      CFG_ORIGIN_Y: org_y = value[31:0];
      CFG_ORIGIN_Z: org_z = value[31:0];
      CFG_ROT_COL0: rot_col[0] = value;
      CFG_ROT_COL1: rot_col[1] = value;
      CFG_ROT_COL2: rot_col[2] = value;
      default: ;
    endcase
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= {z, y, x}; in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_point({z, y, x}, last);
    items_sent++;
  endtask

  task automatic drain;
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_corners.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    corner_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_corners.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[2:0], -1);
      end else begin
        want = expected_corners.pop_front();
        if (out_tdata[2:0] != want.point_index)
          report_mismatch("point_index", out_tdata[2:0], want.point_index);
        if (out_tdata[34:3] != want.radius)
          report_mismatch("radius", out_tdata[34:3], want.radius);
        if (out_tdata[54:35] != want.angle)
          report_mismatch("angle", $signed(out_tdata[54:35]), $signed(want.angle));
        if (out_tdata[86:55] != want.height)
          report_mismatch("height", $signed(out_tdata[86:55]), $signed(want.height));
        if (out_tuser != want.range_error)
          report_mismatch("range_error", out_tuser, want.range_error);
        if (out_tlast != want.last_result)
          report_mismatch("last_result", out_tlast, want.last_result);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed;
    write_reg(CFG_ORIGIN_X, 48'd0); write_reg(CFG_ORIGIN_Y, 48'd0);
    write_reg(CFG_ORIGIN_Z, 48'd0);
    write_reg(CFG_ROT_COL0, 48'd16384); write_reg(CFG_ROT_COL1, 48'd1073741824);
    write_reg(CFG_ROT_COL2, 48'd70368744177664);
    // point on the axis, then single point element
    send_point(0, 0, 32'h0001_0000, 1);
    // three quadrants, spread beyond pi gets wrapped
    send_point(32'h0001_0000, 32'h0000_1000, 0, 0);
    send_point(32'hFFFF_0000, 32'h0000_1000, 0, 0);
    send_point(32'hFFFF_0000, 32'hFFFF_F000, 0, 1);
    // spread beyond pi even after wrapping
    send_point(32'h0001_0000, 0, 0, 0);
    send_point(0, 32'h0001_0000, 0, 0);
    send_point(32'hFFFF_0000, 0, 0, 0);
    send_point(0, 32'hFFFF_0000, 0, 1);
    // extremes, saturated radius and height
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    // store full: points beyond eight are dropped
    for (int i = 0; i < 10; i++) send_point(rand_coord(), rand_coord(), rand_coord(), i == 9);
    drain();
    // extreme origin and matrix
    write_reg(CFG_ORIGIN_X, 48'h7FFF_FFFF); write_reg(CFG_ORIGIN_Y, 48'h8000_0000);
    write_reg(CFG_ORIGIN_Z, 48'h8000_0000);
    write_reg(CFG_ROT_COL0, 48'h7FFF_7FFF_7FFF); write_reg(CFG_ROT_COL1, 48'h8000_8000_8000);
    write_reg(CFG_ROT_COL2, 48'hFFFF_FFFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1);
    drain();
  endtask

  task automatic test_random_elements(input int n_items, input int idle, input int stall);
    int left, pts;
    send_idle_pct = idle; recv_stall_pct = stall;
    write_reg(CFG_ORIGIN_X, {16'h0, 32'($urandom)}); write_reg(CFG_ORIGIN_Y, {16'h0, 32'($urandom)});
    write_reg(CFG_ORIGIN_Z, {16'h0, 32'($urandom)});
    write_reg(CFG_ROT_COL0, {rand_entry(), rand_entry(), rand_entry()});
    write_reg(CFG_ROT_COL1, {rand_entry(), rand_entry(), rand_entry()});
    write_reg(CFG_ROT_COL2, {rand_entry(), rand_entry(), rand_entry()});
    left = n_items;
    while (left > 0) begin
      pts = $urandom_range(1, ($urandom_range(9) == 0) ? 10 : 8);
      for (int i = 0; i < pts && left > 0; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), i == pts - 1 || left == 1);
        left--;
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 3000;
    for (int i = 0; i < 24; i++) send_point(rand_coord(), rand_coord(), rand_coord(), i % 3 == 2);
    drain();
  endtask

  initial begin
    org_x = 0; org_y = 0; org_z = 0;
    rot_col[0] = 48'd16384; rot_col[1] = 48'd1073741824; rot_col[2] = 48'd70368744177664;
    stored_count = 0; ang_lo = 524287; ang_hi = -524288;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_elements(70, 0, 0);
    test_random_elements(60, 83, 0);
    test_random_elements(60, 0, 83);
    test_random_elements(60, 38, 38);
    test_backpressure();
    $display("covered %0d points and %0d results over directed cases, four idling mixes",
             items_sent, results_seen);
    $display("and a long output hold-off with extreme origins and rotation matrices");
    if (errors == 0 && expected_corners.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* cartesian_to_cylindrical_corners_core.f */
+incdir+hw/rtl
hw/rtl/c2c_pkg.sv
hw/rtl/c2c_ram.sv
hw/rtl/cartesian_to_cylindrical_corners_core.sv
test/tb_cartesian_to_cylindrical_corners_core.sv
